### rtl/voxel_face_culling_mesher_core_macros.svh
// assertion macros for the voxel face culling mesher
`ifndef VOXEL_FACE_CULLING_MESHER_CORE_MACROS_SVH
`define VOXEL_FACE_CULLING_MESHER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define VFCM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vfcm same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define VFCM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vfcm next-cycle check failed");

`endif

### rtl/vfcm_pkg.sv
// shared types and constants of the voxel face culling mesher
package vfcm_pkg;

	localparam int EDGE_DEF = 16;
	localparam int POS_W    = 4;
	localparam int FACE_W   = 5;
	localparam int MODE_W   = 2;
	localparam int SEL_W    = 3;
	localparam int AXIS_W   = 2;
	localparam int NDIR     = 6;
	localparam int PLANES   = 6;

	typedef enum logic [MODE_W-1:0] {
		MODE_BLOCK = 2'd0,
		MODE_PLANE = 2'd1,
		MODE_QUERY = 2'd2
	} vfcm_mode_t;

	typedef enum logic [SEL_W-1:0] {
		PL_ABOVE = 3'd0,
		PL_BELOW = 3'd1,
		PL_RIGHT = 3'd2,
		PL_LEFT  = 3'd3,
		PL_BACK  = 3'd4,
		PL_FRONT = 3'd5
	} vfcm_plane_t;

	typedef enum logic [2:0] {
		DIR_YP = 3'd0,
		DIR_YN = 3'd1,
		DIR_XP = 3'd2,
		DIR_XN = 3'd3,
		DIR_ZP = 3'd4,
		DIR_ZN = 3'd5
	} vfcm_dir_t;

	typedef enum logic [AXIS_W-1:0] {
		AXIS_Y = 2'd0,
		AXIS_X = 2'd1,
		AXIS_Z = 2'd2
	} vfcm_axis_t;

	// solid bits of the six neighbours, emission order from bit 0 (up) to bit 5 (ft)
	typedef struct packed {
		logic ft;
		logic bk;
		logic lf;
		logic rt;
		logic dn;
		logic up;
	} vfcm_nbr_t;

endpackage

### rtl/vfcm_req_if.sv
// request channel carrying load and query items
interface vfcm_req_if;
	logic                        valid;
	logic                        ready;
	logic [vfcm_pkg::MODE_W-1:0] mode;
	logic [vfcm_pkg::POS_W-1:0]  pos_x;
	logic [vfcm_pkg::POS_W-1:0]  pos_y;
	logic [vfcm_pkg::POS_W-1:0]  pos_z;
	logic [vfcm_pkg::SEL_W-1:0]  plane_sel;
	logic                        solid;

	modport source (output valid, mode, pos_x, pos_y, pos_z, plane_sel, solid, input ready);
	modport sink (input valid, mode, pos_x, pos_y, pos_z, plane_sel, solid, output ready);
endinterface

### rtl/vfcm_face_if.sv
// face channel carrying one emitted face per transfer
interface vfcm_face_if;
	logic                        valid;
	logic                        ready;
	logic [vfcm_pkg::FACE_W-1:0] face_x;
	logic [vfcm_pkg::FACE_W-1:0] face_y;
	logic [vfcm_pkg::FACE_W-1:0] face_z;
	logic [vfcm_pkg::AXIS_W-1:0] face_axis;
	logic                        back_facing;
	logic                        last_face;

	modport source (output valid, face_x, face_y, face_z, face_axis, back_facing, last_face,
		input ready);
	modport sink (input valid, face_x, face_y, face_z, face_axis, back_facing, last_face,
		output ready);
endinterface

### rtl/vfcm_row_mem.sv
// block map row memory: one z column per entry, bit write, registered read
module vfcm_row_mem #(
	parameter int EDGE = vfcm_pkg::EDGE_DEF
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(EDGE*EDGE)-1:0]     waddr,
	input  logic [$clog2(EDGE)-1:0]          wbit,
	input  logic                             wdata,
	input  logic                             re,
	input  logic [$clog2(EDGE*EDGE)-1:0]     raddr,
	output logic [EDGE-1:0]                  rdata
);
	localparam int DEPTH = EDGE * EDGE;

	logic [EDGE-1:0] mem [DEPTH];
	logic [EDGE-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr][wbit] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### rtl/vfcm_plane_store.sv
// six boundary planes of the neighbouring sub-chunks with registered lookup
module vfcm_plane_store #(
	parameter int EDGE = vfcm_pkg::EDGE_DEF
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [vfcm_pkg::SEL_W-1:0]   sel,
	input  logic [$clog2(EDGE)-1:0]      wa,
	input  logic [$clog2(EDGE)-1:0]      wb,
	input  logic                         wdata,
	input  logic                         re,
	input  logic [$clog2(EDGE)-1:0]      qx,
	input  logic [$clog2(EDGE)-1:0]      qy,
	input  logic [$clog2(EDGE)-1:0]      qz,
	output vfcm_pkg::vfcm_nbr_t          rdata
);
	logic [EDGE-1:0]     pl_q [vfcm_pkg::PLANES][EDGE];
	vfcm_pkg::vfcm_nbr_t rd_q;

	always_ff @(posedge clk) begin
		for (int p = 0; p < vfcm_pkg::PLANES; p++) begin
			if (we && sel == vfcm_pkg::SEL_W'(p)) begin
				pl_q[p][wa][wb] <= wdata;
			end
		end
		if (re) begin
			rd_q.up <= pl_q[vfcm_pkg::PL_ABOVE][qx][qz];
			rd_q.dn <= pl_q[vfcm_pkg::PL_BELOW][qx][qz];
			rd_q.rt <= pl_q[vfcm_pkg::PL_RIGHT][qy][qz];
			rd_q.lf <= pl_q[vfcm_pkg::PL_LEFT][qy][qz];
			rd_q.bk <= pl_q[vfcm_pkg::PL_BACK][qx][qy];
			rd_q.ft <= pl_q[vfcm_pkg::PL_FRONT][qx][qy];
		end
	end

	assign rdata = rd_q;
endmodule

### rtl/vfcm_face_emit.sv
// face emitter: holds the open-side mask of one query and sends one face a cycle while face.ready is high
module vfcm_face_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        self_solid,
	input  vfcm_pkg::vfcm_nbr_t         nbr,
	input  logic [vfcm_pkg::POS_W-1:0]  pos_x,
	input  logic [vfcm_pkg::POS_W-1:0]  pos_y,
	input  logic [vfcm_pkg::POS_W-1:0]  pos_z,
	vfcm_face_if.source                 face
);
	logic                        em_valid_q;
	logic [vfcm_pkg::NDIR-1:0]   em_mask_q;
	logic [vfcm_pkg::POS_W-1:0]  em_x_q;
	logic [vfcm_pkg::POS_W-1:0]  em_y_q;
	logic [vfcm_pkg::POS_W-1:0]  em_z_q;

	logic [vfcm_pkg::NDIR-1:0]   mask_in;
	logic [vfcm_pkg::NDIR-1:0]   rest;
	vfcm_pkg::vfcm_dir_t         dir;
	logic                        last;
	logic                        take;

	assign mask_in = self_solid ? ~vfcm_pkg::NDIR'(nbr) : '0;

	// lowest set bit is the next face
	always_comb begin
		dir = vfcm_pkg::DIR_YP;
		for (int i = vfcm_pkg::NDIR - 1; i >= 0; i--) begin
			if (em_mask_q[i]) begin
				dir = vfcm_pkg::vfcm_dir_t'(3'(i));
			end
		end
	end

	assign rest     = em_mask_q & ~(vfcm_pkg::NDIR'(1) << dir);
	assign last     = (rest == '0);
	assign take     = face.valid && face.ready;
	assign in_ready = !em_valid_q || (take && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_valid_q <= 1'b0;
			em_mask_q  <= '0;
		end else if (in_valid && in_ready) begin
			em_valid_q <= (mask_in != '0);
			em_mask_q  <= mask_in;
		end else if (take) begin
			em_valid_q <= !last;
			em_mask_q  <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			em_x_q <= pos_x;
			em_y_q <= pos_y;
			em_z_q <= pos_z;
		end
	end

	assign face.valid       = em_valid_q;
	assign face.face_x      = vfcm_pkg::FACE_W'(em_x_q) +
		vfcm_pkg::FACE_W'(dir == vfcm_pkg::DIR_XP);
	assign face.face_y      = vfcm_pkg::FACE_W'(em_y_q) +
		vfcm_pkg::FACE_W'(dir == vfcm_pkg::DIR_YP);
	assign face.face_z      = vfcm_pkg::FACE_W'(em_z_q) +
		vfcm_pkg::FACE_W'(dir == vfcm_pkg::DIR_ZP);
	// normal axis and sign straight from the direction code
	assign face.face_axis   = dir[2:1];
	assign face.back_facing = dir[0];
	assign face.last_face   = last;
endmodule

### rtl/voxel_face_culling_mesher_core.sv
// top level of the voxel face culling mesher
// req channel: mode 0 writes one block bit, mode 1 writes one neighbour plane bit,
// mode 2 queries the faces of one block. A request is taken when valid and ready are high.
// face channel: one transfer per visible face, order +y, -y, +x, -x, +z, -z,
// last_face marks the final face of a query; air blocks and buried blocks send nothing.
// loads finish at the accepting edge; a query that follows in the next cycle sees them.
// a query reads its block row and four neighbour rows from five copies of the block
// map, plus the six plane bits, all registered at acceptance; the face emitter then
// latches the open-side mask, and its output register drives the face channel.
// loads: one per cycle while req.ready is high; a query holds the single face output
// register until its last face is taken, and the next query may enter in that cycle.
// reset clears the pipeline valid and the emitter valid and mask state only; the block
// map and the planes hold nothing defined until written.
// when the face receiver stalls the face holds, one query waits behind it and req.ready
// drops until the emitter frees.
`include "voxel_face_culling_mesher_core_macros.svh"

module voxel_face_culling_mesher_core #(
	parameter int EDGE = vfcm_pkg::EDGE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	vfcm_req_if.sink    req,
	vfcm_face_if.source face
);
	localparam int CW   = $clog2(EDGE);
	localparam int AW   = $clog2(EDGE * EDGE);
	localparam int NROW = 5;

	localparam int ROW_SELF = 0;
	localparam int ROW_YP   = 1;
	localparam int ROW_YN   = 2;
	localparam int ROW_XP   = 3;
	localparam int ROW_XN   = 4;

	logic                        accept;
	logic                        x_in;
	logic                        y_in;
	logic                        z_in;
	logic                        blk_we;
	logic                        pl_we;
	logic                        qry_go;
	logic [AW-1:0]               rd_addr [NROW];

	logic                        s1_valid_q;
	logic                        s1_ready;
	logic [vfcm_pkg::POS_W-1:0]  pos_x_s1;
	logic [vfcm_pkg::POS_W-1:0]  pos_y_s1;
	logic [vfcm_pkg::POS_W-1:0]  pos_z_s1;
	logic [EDGE-1:0]             row_s1 [NROW];
	vfcm_pkg::vfcm_nbr_t         pl_s1;

	logic [CW-1:0]               zi;
	logic [CW-1:0]               zi_up;
	logic [CW-1:0]               zi_dn;
	logic                        y_top;
	logic                        y_bot;
	logic                        x_top;
	logic                        x_bot;
	logic                        z_top;
	logic                        z_bot;
	logic                        self_solid;
	vfcm_pkg::vfcm_nbr_t         nbr;
	logic                        face_take;

	assign accept = req.valid && req.ready;
	assign x_in   = int'(req.pos_x) < EDGE;
	assign y_in   = int'(req.pos_y) < EDGE;
	assign z_in   = int'(req.pos_z) < EDGE;

	assign blk_we = accept && req.mode == vfcm_pkg::MODE_BLOCK && x_in && y_in && z_in;
	assign pl_we  = accept && req.mode == vfcm_pkg::MODE_PLANE && x_in && y_in &&
		int'(req.plane_sel) < vfcm_pkg::PLANES;
	assign qry_go = accept && req.mode == vfcm_pkg::MODE_QUERY && x_in && y_in && z_in;

	// row addresses of the block and its in-plane neighbours
	assign rd_addr[ROW_SELF] = AW'(int'(req.pos_x) * EDGE + int'(req.pos_y));
	assign rd_addr[ROW_YP]   = AW'(int'(req.pos_x) * EDGE + int'(req.pos_y) + 1);
	assign rd_addr[ROW_YN]   = AW'(int'(req.pos_x) * EDGE + int'(req.pos_y) - 1);
	assign rd_addr[ROW_XP]   = AW'((int'(req.pos_x) + 1) * EDGE + int'(req.pos_y));
	assign rd_addr[ROW_XN]   = AW'((int'(req.pos_x) - 1) * EDGE + int'(req.pos_y));

	for (genvar i = 0; i < NROW; i++) begin : g_row
		vfcm_row_mem #(
			.EDGE (EDGE)
		) u_row_mem (
			.clk   (clk),
			.we    (blk_we),
			.waddr (rd_addr[ROW_SELF]),
			.wbit  (CW'(req.pos_z)),
			.wdata (req.solid),
			.re    (qry_go),
			.raddr (rd_addr[i]),
			.rdata (row_s1[i])
		);
	end

	vfcm_plane_store #(
		.EDGE (EDGE)
	) u_plane_store (
		.clk   (clk),
		.we    (pl_we),
		.sel   (req.plane_sel),
		.wa    (CW'(req.pos_x)),
		.wb    (CW'(req.pos_y)),
		.wdata (req.solid),
		.re    (qry_go),
		.qx    (CW'(req.pos_x)),
		.qy    (CW'(req.pos_y)),
		.qz    (CW'(req.pos_z)),
		.rdata (pl_s1)
	);

	assign req.ready = !s1_valid_q || s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (qry_go) begin
			s1_valid_q <= 1'b1;
		end else if (s1_ready) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (qry_go) begin
			pos_x_s1 <= req.pos_x;
			pos_y_s1 <= req.pos_y;
			pos_z_s1 <= req.pos_z;
		end
	end

	// neighbour lookup, boundary planes past the sub-chunk edge
	assign zi    = CW'(pos_z_s1);
	assign zi_up = CW'({1'b0, pos_z_s1} + 5'd1);
	assign zi_dn = CW'(pos_z_s1 - 4'd1);
	assign y_top = int'(pos_y_s1) + 1 >= EDGE;
	assign y_bot = pos_y_s1 == '0;
	assign x_top = int'(pos_x_s1) + 1 >= EDGE;
	assign x_bot = pos_x_s1 == '0;
	assign z_top = int'(pos_z_s1) + 1 >= EDGE;
	assign z_bot = pos_z_s1 == '0;

	assign self_solid = row_s1[ROW_SELF][zi];
	assign nbr.up = y_top ? pl_s1.up : row_s1[ROW_YP][zi];
	assign nbr.dn = y_bot ? pl_s1.dn : row_s1[ROW_YN][zi];
	assign nbr.rt = x_top ? pl_s1.rt : row_s1[ROW_XP][zi];
	assign nbr.lf = x_bot ? pl_s1.lf : row_s1[ROW_XN][zi];
	assign nbr.bk = z_top ? pl_s1.bk : row_s1[ROW_SELF][zi_up];
	assign nbr.ft = z_bot ? pl_s1.ft : row_s1[ROW_SELF][zi_dn];

	vfcm_face_emit u_face_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s1_valid_q),
		.in_ready   (s1_ready),
		.self_solid (self_solid),
		.nbr        (nbr),
		.pos_x      (pos_x_s1),
		.pos_y      (pos_y_s1),
		.pos_z      (pos_z_s1),
		.face       (face)
	);

	assign face_take = face.valid && face.ready;

	`VFCM_ASSERT_NEXT(a_more_faces, face_take && !face.last_face, face.valid)
	`VFCM_ASSERT_NEXT(a_idle_after_last, face_take && face.last_face && !s1_valid_q, !face.valid)
	`VFCM_ASSERT_SAME(a_pos_y_origin, face.valid && !face.back_facing && face.face_axis == vfcm_pkg::AXIS_Y, face.face_y != '0)
endmodule
